FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/bct_pkg.sv
// Package: types, constants and helper functions of the centroid tracker.
package bct_pkg;

   localparam int CoordW = 10;
   localparam int SumW   = 31;
   localparam int CountW = 21;
   localparam int PosW   = 11;
   localparam int ZoneW  = 12;
   localparam int RootW  = 19;
   localparam int HalfW  = 20;
   localparam int CsrW   = 21;
   localparam int CsrIdxW = 3;
   localparam int UnitW  = 24;

   localparam int MaxWidthDefault  = 1024;
   localparam int MaxHeightDefault = 1024;

   localparam logic [CountW-1:0] CountMax = '1;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CsrStepMin   = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrStepMax   = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrMinPixels = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrMargin    = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrWidth     = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrHeight    = 3'd5;

   // Register reset values
   localparam logic [9:0]        StepMinReset   = 10'd5;
   localparam logic [9:0]        StepMaxReset   = 10'd100;
   localparam logic [CountW-1:0] MinPixelsReset = 21'd10;
   localparam logic [9:0]        MarginReset    = 10'd85;
   localparam logic [10:0]       WidthReset     = 11'd640;
   localparam logic [10:0]       HeightReset    = 11'd480;

   localparam logic signed [ZoneW-1:0] ZoneLow  = -12'sd1024;
   localparam logic signed [ZoneW-1:0] ZoneHigh = 12'sd2047;

   typedef struct packed {
      logic signed [ZoneW-1:0] left;
      logic signed [ZoneW-1:0] top;
      logic signed [ZoneW-1:0] right;
      logic signed [ZoneW-1:0] bottom;
   } zone_type;

   typedef struct packed {
      logic [SumW-1:0]   sum_x;
      logic [SumW-1:0]   sum_y;
      logic [CountW-1:0] count;
   } totals_type;

   typedef struct packed {
      logic [9:0]        min_step;
      logic [9:0]        max_step;
      logic [CountW-1:0] min_pixels;
      logic [9:0]        margin;
      logic [10:0]       width;
      logic [10:0]       height;
   } cfg_type;

   // Step one axis toward its target.
   function automatic logic signed [PosW-1:0] smooth_axis(
         input logic signed [PosW-1:0] pos,
         input logic signed [PosW-1:0] tgt,
         input logic [9:0] smin,
         input logic [9:0] smax);
      logic signed [PosW:0] diff;
      logic [PosW-1:0]      span;
      logic [PosW-1:0]      s;
      logic signed [PosW:0] moved;
      diff = {pos[PosW-1], pos} - {tgt[PosW-1], tgt};
      span = diff[PosW] ? PosW'(-diff) : diff[PosW-1:0];
      s = span >> 1;
      if (s > {1'b0, smax}) s = {1'b0, smax};
      if (s < {1'b0, smin}) s = {1'b0, smin};
      moved = diff[PosW] ? ({pos[PosW-1], pos} + $signed({1'b0, s}))
                         : ({pos[PosW-1], pos} - $signed({1'b0, s}));
      if (span > {1'b0, smin}) return moved[PosW-1:0];
      else return pos;
   endfunction

   // Position +/- half size, truncated toward zero, clamped.
   function automatic logic signed [ZoneW-1:0] zone_bound(
         input logic signed [PosW-1:0] pos,
         input logic [HalfW-1:0] h,
         input logic upper);
      logic signed [31:0] v;
      logic signed [31:0] q;
      v = $signed({{12{pos[PosW-1]}}, pos, 9'b0});
      v = upper ? v + $signed({12'b0, h}) : v - $signed({12'b0, h});
      q = v[31] ? ((v + 32'sd511) >>> 9) : (v >>> 9);
      if (q < 32'(ZoneLow)) return ZoneLow;
      else if (q > 32'(ZoneHigh)) return ZoneHigh;
      else return q[ZoneW-1:0];
   endfunction

endpackage

FILE: design/blob_centroid_tracker.sv
// Sequence: a pixel without end of frame is added to the registered sums; an
// end-of-frame pixel starts the solver, which runs DIVX, DIVY, ROOT, TRACK,
// ZONE and DONE (count 0 skips to TRACK). Throughput: one pixel per cycle during
// the frame; after end of frame the input stalls while the solver is busy.
// Reset: synchronous, active high; registers, sums, position and zone return
// to their initial values.
module blob_centroid_tracker import bct_pkg::*; #(
   parameter int MAX_WIDTH  = MaxWidthDefault,
   parameter int MAX_HEIGHT = MaxHeightDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // pixel_x[9:0], pixel_y[19:10], zero fill
   input  logic                req_tuser,   // in_mask
   input  logic                req_tlast,   // end_of_frame
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [119:0]        rsp_tdata,   // centroid_x, centroid_y, pixel_count,
                                            // tracked_x, tracked_y, zone_left_out,
                                            // zone_top_out, zone_right_out,
                                            // zone_bottom_out, zero fill
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrW-1:0]     csr_wdata
);

   cfg_type                cfg_ff;
   totals_type             totals;
   zone_type               zone, out_zone;
   logic                   busy, accept;
   logic signed [PosW-1:0] cx, cy, tx, ty;
   logic [CountW-1:0]      count;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_step   <= StepMinReset;
         cfg_ff.max_step   <= StepMaxReset;
         cfg_ff.min_pixels <= MinPixelsReset;
         cfg_ff.margin     <= MarginReset;
         cfg_ff.width      <= WidthReset;
         cfg_ff.height     <= HeightReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrStepMin:   cfg_ff.min_step   <= csr_wdata[9:0];
            CsrStepMax:   cfg_ff.max_step   <= csr_wdata[9:0];
            CsrMinPixels: cfg_ff.min_pixels <= csr_wdata;
            CsrMargin:    cfg_ff.margin     <= csr_wdata[9:0];
            CsrWidth:     cfg_ff.width      <= csr_wdata[10:0];
            CsrHeight:    cfg_ff.height     <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   assign req_tready = ~busy;
   assign accept     = req_tvalid & ~busy;

   bct_accum u_accum (
      .clock, .reset, .accept,
      .pixel_x(req_tdata[9:0]), .pixel_y(req_tdata[19:10]),
      .in_mask(req_tuser), .end_of_frame(req_tlast),
      .zone, .totals
   );

   bct_solver #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_solver (
      .clock, .reset,
      .start(accept & req_tlast), .totals, .cfg(cfg_ff),
      .out_ready(rsp_tready), .busy, .zone,
      .out_valid(rsp_tvalid), .out_cx(cx), .out_cy(cy), .out_count(count),
      .out_tx(tx), .out_ty(ty), .out_zone
   );

   assign rsp_tdata = {7'b0, out_zone.bottom, out_zone.right, out_zone.top,
                       out_zone.left, ty, tx, count, cy, cx};

endmodule

FILE: design/bct_accum.sv
// Pixel accumulator: sums x, y and count of set pixels inside the zone.
module bct_accum import bct_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CoordW-1:0] pixel_x,
   input  logic [CoordW-1:0] pixel_y,
   input  logic              in_mask,
   input  logic              end_of_frame,
   input  zone_type          zone,
   output totals_type        totals
);

   totals_type acc_ff, acc_in;
   logic       hit;

   // Test zone membership and saturation
   always_comb begin
      hit = in_mask
         && $signed({2'b0, pixel_x}) >= zone.left && $signed({2'b0, pixel_x}) < zone.right
         && $signed({2'b0, pixel_y}) >= zone.top  && $signed({2'b0, pixel_y}) < zone.bottom
         && acc_ff.count != CountMax;
      totals = acc_ff;
      if (hit) begin
         totals.sum_x = acc_ff.sum_x + SumW'(pixel_x);
         totals.sum_y = acc_ff.sum_y + SumW'(pixel_y);
         totals.count = acc_ff.count + 1'b1;
      end
      acc_in = acc_ff;
      if (accept) begin
         acc_in = end_of_frame ? '0 : totals;
      end
   end

   // Hold running sums; clear at end of frame
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: design/bct_cmpsub.sv
// Shared compare-subtract unit used by the divider and the square root.
module bct_cmpsub import bct_pkg::*; (
   input  logic [UnitW-1:0] a,
   input  logic [UnitW-1:0] b,
   output logic             ge,
   output logic [UnitW-1:0] diff
);

   logic [UnitW:0] full;

   // Subtract once, take the borrow as the compare
   always_comb begin
      full = {1'b0, a} - {1'b0, b};
      ge   = ~full[UnitW];
      diff = full[UnitW-1:0];
   end

endmodule

FILE: design/bct_solver.sv
// End-of-frame sequencer: divides, takes the root, tracks and sizes the zone.
module bct_solver import bct_pkg::*; #(
   parameter int MAX_WIDTH  = MaxWidthDefault,
   parameter int MAX_HEIGHT = MaxHeightDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  totals_type              totals,
   input  cfg_type                 cfg,
   input  logic                    out_ready,
   output logic                    busy,
   output zone_type                zone,
   output logic                    out_valid,
   output logic signed [PosW-1:0]  out_cx,
   output logic signed [PosW-1:0]  out_cy,
   output logic [CountW-1:0]       out_count,
   output logic signed [PosW-1:0]  out_tx,
   output logic signed [PosW-1:0]  out_ty,
   output zone_type                out_zone
);

   typedef enum logic [2:0] {IDLE, DIVX, DIVY, ROOT, TRACK, ZONE, DONE} state_type;

   localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
   localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

   state_type                state_ff;
   logic [4:0]               cnt_ff;
   logic [UnitW-1:0]         rem_ff;
   logic [37:0]              num_ff;
   logic [SumW-1:0]          quo_ff;
   logic [SumW-1:0]          sy_ff;
   logic [CountW-1:0]        count_ff;
   logic signed [PosW-1:0]   cx_ff, cy_ff, px_ff, py_ff;
   logic [RootW-1:0]         root_ff;
   zone_type                 zone_ff;
   logic                     valid_ff;
   logic signed [PosW-1:0]   ocx_ff, ocy_ff, otx_ff, oty_ff;
   logic [CountW-1:0]        ocount_ff;
   zone_type                 ozone_ff;

   logic [UnitW-1:0]         ua, ub, udiff;
   logic                     uge;
   logic [UnitW-1:0]         rem_in;
   logic [SumW-1:0]          quo_in;
   logic signed [PosW-1:0]   bx, by;
   logic [HalfW-1:0]         h;
   logic [12:0]              fw, fh;

   // Feed the shared unit from the running step
   always_comb begin
      if (state_ff == ROOT) begin
         ua = {rem_ff[UnitW-3:0], num_ff[37:36]};
         ub = {3'b0, quo_ff[RootW-1:0], 2'b01};
      end else begin
         ua = {rem_ff[UnitW-2:0], num_ff[SumW-1]};
         ub = {3'b0, count_ff};
      end
      rem_in = uge ? udiff : ua;
      quo_in = {quo_ff[SumW-2:0], uge};
   end

   bct_cmpsub u_unit (.a(ua), .b(ub), .ge(uge), .diff(udiff));

   // Lost position jumps to the centroid before smoothing; form half size and frame clamps
   always_comb begin
      if (px_ff == -11'sd1 || py_ff == -11'sd1) begin
         bx = cx_ff;
         by = cy_ff;
      end else begin
         bx = px_ff;
         by = py_ff;
      end
      h  = HalfW'(root_ff) + HalfW'({cfg.margin, 8'b0});
      fw = ({2'b0, cfg.width}  < MaxW) ? {2'b0, cfg.width}  : MaxW;
      fh = ({2'b0, cfg.height} < MaxH) ? {2'b0, cfg.height} : MaxH;
   end

   // Sequence the frame-end work and hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         valid_ff     <= 1'b0;
         px_ff        <= -11'sd1;
         py_ff        <= -11'sd1;
         zone_ff.left   <= '0;
         zone_ff.top    <= '0;
         zone_ff.right  <= 12'sd640;
         zone_ff.bottom <= 12'sd480;
      end else begin
         if (state_ff == DONE && (!valid_ff || out_ready)) valid_ff <= 1'b1;
         else if (valid_ff && out_ready) valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  count_ff <= totals.count;
                  sy_ff    <= totals.sum_y;
                  num_ff   <= 38'(totals.sum_x);
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= 5'(SumW - 1);
                  cx_ff    <= -11'sd1;
                  cy_ff    <= -11'sd1;
                  root_ff  <= '0;
                  state_ff <= (totals.count == '0) ? TRACK : DIVX;
               end
            end
            DIVX, DIVY: begin
               if (cnt_ff == '0) begin
                  rem_ff <= '0;
                  quo_ff <= '0;
                  if (state_ff == DIVX) begin
                     cx_ff    <= quo_in[PosW-1:0];
                     num_ff   <= 38'(sy_ff);
                     cnt_ff   <= 5'(SumW - 1);
                     state_ff <= DIVY;
                  end else begin
                     cy_ff    <= quo_in[PosW-1:0];
                     num_ff   <= {1'b0, count_ff, 16'b0};
                     cnt_ff   <= 5'(RootW - 1);
                     state_ff <= ROOT;
                  end
               end else begin
                  rem_ff <= rem_in;
                  quo_ff <= quo_in;
                  num_ff <= num_ff << 1;
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ROOT: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               num_ff <= num_ff << 2;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  root_ff  <= quo_in[RootW-1:0];
                  state_ff <= TRACK;
               end
            end
            TRACK: begin
               if (count_ff > cfg.min_pixels) begin
                  px_ff <= smooth_axis(bx, cx_ff, cfg.min_step, cfg.max_step);
                  py_ff <= smooth_axis(by, cy_ff, cfg.min_step, cfg.max_step);
               end else begin
                  px_ff <= -11'sd1;
                  py_ff <= -11'sd1;
               end
               state_ff <= ZONE;
            end
            ZONE: begin
               if (count_ff == '0) begin
                  zone_ff.left   <= '0;
                  zone_ff.top    <= '0;
                  zone_ff.right  <= fw[ZoneW-1:0];
                  zone_ff.bottom <= fh[ZoneW-1:0];
               end else begin
                  zone_ff.left   <= zone_bound(px_ff, h, 1'b0);
                  zone_ff.top    <= zone_bound(py_ff, h, 1'b0);
                  zone_ff.right  <= zone_bound(px_ff, h, 1'b1);
                  zone_ff.bottom <= zone_bound(py_ff, h, 1'b1);
               end
               state_ff <= DONE;
            end
            DONE: begin
               if (!valid_ff || out_ready) begin
                  ocx_ff    <= cx_ff;
                  ocy_ff    <= cy_ff;
                  ocount_ff <= count_ff;
                  otx_ff    <= px_ff;
                  oty_ff    <= py_ff;
                  ozone_ff  <= zone_ff;
                  state_ff  <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != IDLE);
   assign zone      = zone_ff;
   assign out_valid = valid_ff;
   assign out_cx    = ocx_ff;
   assign out_cy    = ocy_ff;
   assign out_count = ocount_ff;
   assign out_tx    = otx_ff;
   assign out_ty    = oty_ff;
   assign out_zone  = ozone_ff;

endmodule

FILE: design/bct_checker.sv
// Port checker for the centroid tracker, bound to the top level.
`include "assert_macros.svh"
module bct_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [119:0] rsp_tdata
);

   logic [10:0] cen_x;
   logic [20:0] n_pix;
   logic [10:0] trk_x;
   logic [11:0] z_left;

   // Pick result fields out of the transaction
   assign cen_x  = rsp_tdata[10:0];
   assign n_pix  = rsp_tdata[42:22];
   assign trk_x  = rsp_tdata[53:43];
   assign z_left = rsp_tdata[76:65];

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `ASSERT_IMP(a_none_centroid, clock, reset, rsp_tvalid, (n_pix == '0) == (cen_x == '1))
   `ASSERT_IMP(a_empty_lost, clock, reset, rsp_tvalid && n_pix == '0, trk_x == '1 && z_left == '0)

endmodule

bind blob_centroid_tracker bct_checker u_bct_checker (.*);
